// ----- design/urc_pkg.sv -----
// Shared types, constants and helper functions for the ultrasonic ranger controller.
// No dependencies; every other design file refers to this package by scoped names.
package urc_pkg;

  localparam int RING_SLOTS      = 6;
  localparam int TRIGGER_TICKS   = 10;
  localparam int ECHO_COUNT_BITS = 16;

  localparam int RING_IDX_W = $clog2(RING_SLOTS);
  localparam int TRIG_CNT_W = $clog2(TRIGGER_TICKS + 1);
  localparam int DIST_W     = 11;
  localparam int COUNT_W    = 3;
  localparam int RATE_W     = 5;
  localparam int PERIOD_W   = 20;
  localparam int ACTION_W   = 3;
  localparam int ADDR_W     = 3;
  localparam int DATA_W     = 32;

  localparam int CM_DIVISOR = 58;
  localparam int DIST_MAX   = 2047;
  localparam int RATE_MAX   = 16;

  // floor(x / 58) as floor(x * M / 2^S), exact for x below 2^ECHO_COUNT_BITS
  localparam int DIV_SHIFT  = ECHO_COUNT_BITS + $clog2(CM_DIVISOR);
  localparam int DIV_MULT   = ((1 << DIV_SHIFT) + CM_DIVISOR - 1) / CM_DIVISOR;
  localparam int DIV_MULT_W = $clog2(DIV_MULT + 1);
  localparam int PROD_W     = ECHO_COUNT_BITS + DIV_MULT_W;

  localparam logic [ECHO_COUNT_BITS-1:0] ECHO_MAX = '1;

  // periodic period in microsecond ticks, indexed by rate - 1
  localparam int PERIOD_TICKS [RATE_MAX] = '{
    1000000, 500000, 333000, 250000, 200000, 166000, 142000, 125000,
    111000, 100000, 90000, 83000, 76000, 71000, 66000, 62000
  };

  typedef enum logic [ACTION_W-1:0] {
    ACT_TICK    = 3'd0,
    ACT_MEASURE = 3'd1,
    ACT_STOP    = 3'd2,
    ACT_READ    = 3'd3,
    ACT_CLEAR   = 3'd4
  } action_t;

  localparam logic REG_MODE = 1'b0;
  localparam logic REG_RATE = 1'b1;

  typedef struct packed {
    logic              valid;
    logic [DIST_W-1:0] data;
  } push_t;

  typedef struct packed {
    logic advance;
    logic read;
    logic clear;
  } ring_cmd_t;

  typedef struct packed {
    logic               empty;
    logic               read_valid;
    logic [DIST_W-1:0]  read_data;
    logic [COUNT_W-1:0] count;
  } ring_status_t;

  function automatic logic [RING_IDX_W-1:0] ring_wrap(input logic [RING_IDX_W-1:0] idx);
    return (idx == RING_IDX_W'(RING_SLOTS - 1)) ? '0 : idx + RING_IDX_W'(1);
  endfunction

  function automatic logic [DIST_W-1:0] echo_to_cm(input logic [ECHO_COUNT_BITS-1:0] w);
    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] quot;
    prod = PROD_W'(w) * PROD_W'(DIV_MULT);
    quot = prod >> DIV_SHIFT;
    if (quot > PROD_W'(DIST_MAX)) begin
      return DIST_W'(DIST_MAX);
    end
    return DIST_W'(quot);
  endfunction

  function automatic logic [PERIOD_W-1:0] period_ticks(input logic [RATE_W-1:0] rate);
    logic [3:0] idx;
    if (rate == '0) begin
      idx = '0;
    end else if (rate > RATE_W'(RATE_MAX)) begin
      idx = 4'(RATE_MAX - 1);
    end else begin
      idx = 4'(rate - RATE_W'(1));
    end
    return PERIOD_W'(PERIOD_TICKS[idx]);
  endfunction

endpackage

// ----- design/urc_measure.sv -----
// Measurement sequencer: trigger pulse, echo wait, echo width count and cm conversion.
// Depends on urc_pkg.
module urc_measure (
  input  logic          clk,
  input  logic          rst,
  input  logic          advance,
  input  logic          echo,
  input  logic          start,
  output logic          trig,
  output urc_pkg::push_t push
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_TRIG,
    PH_WAIT,
    PH_ECHO
  } phase_t;

  phase_t                               phase;
  phase_t                               phase_adv;
  phase_t                               phase_next;
  logic [urc_pkg::TRIG_CNT_W-1:0]       ticks_left;
  logic [urc_pkg::TRIG_CNT_W-1:0]       ticks_left_next;
  logic [urc_pkg::ECHO_COUNT_BITS-1:0]  echo_width;
  logic [urc_pkg::ECHO_COUNT_BITS-1:0]  echo_width_next;

  always_comb begin
    phase_adv       = phase;
    ticks_left_next = ticks_left;
    echo_width_next = echo_width;
    trig            = 1'b0;
    push.valid      = 1'b0;
    push.data       = urc_pkg::echo_to_cm(echo_width);
    unique case (phase)
      PH_IDLE: begin
      end
      PH_TRIG: begin
        trig = 1'b1;
        if (ticks_left <= urc_pkg::TRIG_CNT_W'(1)) begin
          ticks_left_next = '0;
          phase_adv       = PH_WAIT;
        end else begin
          ticks_left_next = ticks_left - urc_pkg::TRIG_CNT_W'(1);
        end
      end
      PH_WAIT: begin
        if (echo) begin
          echo_width_next = urc_pkg::ECHO_COUNT_BITS'(1);
          phase_adv       = PH_ECHO;
        end
      end
      PH_ECHO: begin
        if (echo) begin
          if (echo_width != urc_pkg::ECHO_MAX) begin
            echo_width_next = echo_width + urc_pkg::ECHO_COUNT_BITS'(1);
          end
        end else begin
          push.valid      = 1'b1;
          echo_width_next = '0;
          phase_adv       = PH_IDLE;
        end
      end
      default: begin
      end
    endcase
    phase_next = phase_adv;
    if (start && phase_adv == PH_IDLE) begin
      phase_next      = PH_TRIG;
      ticks_left_next = urc_pkg::TRIG_CNT_W'(urc_pkg::TRIGGER_TICKS);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      ticks_left <= '0;
      echo_width <= '0;
    end else if (advance) begin
      phase      <= phase_next;
      ticks_left <= ticks_left_next;
      echo_width <= echo_width_next;
    end
  end

endmodule

// ----- design/urc_ring.sv -----
// Distance ring: slot registers, write and read indices, overwrite of the oldest entry.
// Depends on urc_pkg.
module urc_ring (
  input  logic                  clk,
  input  logic                  rst,
  input  urc_pkg::ring_cmd_t    cmd,
  input  urc_pkg::push_t        push,
  output urc_pkg::ring_status_t status
);

  logic [urc_pkg::DIST_W-1:0]     slots [urc_pkg::RING_SLOTS];
  logic [urc_pkg::RING_IDX_W-1:0] write_index;
  logic [urc_pkg::RING_IDX_W-1:0] read_index;
  logic [urc_pkg::RING_IDX_W-1:0] w_push;
  logic [urc_pkg::RING_IDX_W-1:0] r_push;
  logic [urc_pkg::RING_IDX_W-1:0] write_index_next;
  logic [urc_pkg::RING_IDX_W-1:0] read_index_next;
  logic [urc_pkg::RING_IDX_W:0]   count_full;

  always_comb begin
    w_push = write_index;
    r_push = read_index;
    if (push.valid) begin
      w_push = urc_pkg::ring_wrap(write_index);
      if (urc_pkg::ring_wrap(write_index) == read_index) begin
        r_push = urc_pkg::ring_wrap(read_index);
      end
    end
    status.empty      = (w_push == r_push);
    status.read_valid = cmd.read && !status.empty;
    // slot being written this cycle is forwarded
    if (push.valid && r_push == write_index) begin
      status.read_data = push.data;
    end else begin
      status.read_data = slots[r_push];
    end
    write_index_next = w_push;
    read_index_next  = status.read_valid ? urc_pkg::ring_wrap(r_push) : r_push;
    if (cmd.clear) begin
      write_index_next = '0;
      read_index_next  = '0;
    end
    if (write_index_next >= read_index_next) begin
      count_full = {1'b0, write_index_next} - {1'b0, read_index_next};
    end else begin
      count_full = {1'b0, write_index_next} + (urc_pkg::RING_IDX_W + 1)'(urc_pkg::RING_SLOTS)
                   - {1'b0, read_index_next};
    end
    status.count = urc_pkg::COUNT_W'(count_full);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_index <= '0;
      read_index  <= '0;
    end else if (cmd.advance) begin
      write_index <= write_index_next;
      read_index  <= read_index_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.advance && push.valid) begin
      slots[write_index] <= push.data;
    end
  end

endmodule

// ----- design/urc_timer.sv -----
// Periodic sampling timer: run flag and microsecond down-counter over the table period.
// Depends on urc_pkg.
module urc_timer (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         advance,
  input  logic                         mode_write,
  input  logic [urc_pkg::ACTION_W-1:0] action,
  input  logic                         periodic_mode,
  input  logic [urc_pkg::RATE_W-1:0]   sample_rate_hz,
  output logic                         fire
);

  logic                         periodic_running;
  logic                         periodic_running_next;
  logic [urc_pkg::PERIOD_W-1:0] period_ticks_left;
  logic [urc_pkg::PERIOD_W-1:0] period_ticks_left_next;
  logic [urc_pkg::PERIOD_W-1:0] period;
  logic                         is_measure;

  always_comb begin
    period                 = urc_pkg::period_ticks(sample_rate_hz);
    is_measure             = (action == urc_pkg::ACT_MEASURE);
    periodic_running_next  = periodic_running;
    period_ticks_left_next = period_ticks_left;
    fire                   = 1'b0;
    if (is_measure) begin
      if (periodic_mode) begin
        periodic_running_next  = 1'b1;
        period_ticks_left_next = period;
      end
    end else if (action == urc_pkg::ACT_STOP) begin
      periodic_running_next = 1'b0;
    end
    if (periodic_running_next && !is_measure) begin
      if (period_ticks_left <= urc_pkg::PERIOD_W'(1)) begin
        period_ticks_left_next = period;
        fire                   = 1'b1;
      end else begin
        period_ticks_left_next = period_ticks_left - urc_pkg::PERIOD_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      periodic_running  <= 1'b0;
      period_ticks_left <= '0;
    end else if (mode_write) begin
      periodic_running <= 1'b0;
    end else if (advance) begin
      periodic_running  <= periodic_running_next;
      period_ticks_left <= period_ticks_left_next;
    end
  end

endmodule

// ----- design/ultrasonic_ranger_controller.sv -----
// Top level of the ultrasonic ranger controller: register port, input and result registers.
// Depends on urc_pkg, urc_measure, urc_ring and urc_timer.
//
//   channel | handshake           | payload
//   --------+---------------------+--------------------------------------------------
//   in      | in_valid, in_ready  | action, echo_level
//   out     | out_valid, out_ready| trigger_level, read_valid, read_empty,
//           |                     | distance_cm, sample_done, stored_count
//   config  | psel, penable, ...  | paddr, pwdata, prdata (mode at 0x0, rate at 0x4)
//
// One tick per cycle unless out_ready stalls: a transfer enters the input register,
// its result is formed in one pass and loaded into the result register on advance.
// While a result waits for out_ready, an empty input register still takes one tick.
// in_ready falls only when both registers are full and out_ready is low.
// Synchronous reset clears the handshake flags, ring indices and sequencer.
module ultrasonic_ranger_controller (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [urc_pkg::ACTION_W-1:0] action,
  input  logic                         echo_level,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         trigger_level,
  output logic                         read_valid,
  output logic                         read_empty,
  output logic [urc_pkg::DIST_W-1:0]   distance_cm,
  output logic                         sample_done,
  output logic [urc_pkg::COUNT_W-1:0]  stored_count,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [urc_pkg::ADDR_W-1:0]   paddr,
  input  logic [urc_pkg::DATA_W-1:0]   pwdata,
  output logic [urc_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);

  logic                         periodic_mode;
  logic [urc_pkg::RATE_W-1:0]   sample_rate_hz;
  logic                         cfg_write;
  logic                         mode_write;

  logic                         s1_valid;
  logic [urc_pkg::ACTION_W-1:0] s1_action;
  logic                         s1_echo;
  logic                         s1_advance;

  logic                         trig;
  logic                         fire;
  logic                         start;
  logic                         is_read;
  urc_pkg::push_t               push;
  urc_pkg::ring_cmd_t           ring_cmd;
  urc_pkg::ring_status_t        ring_status;

  // register port
  assign pready     = 1'b1;
  assign cfg_write  = psel && penable && pwrite && pready;
  assign mode_write = cfg_write && (paddr[2] == urc_pkg::REG_MODE);

  always_comb begin
    if (paddr[2] == urc_pkg::REG_MODE) begin
      prdata = urc_pkg::DATA_W'(periodic_mode);
    end else begin
      prdata = urc_pkg::DATA_W'(sample_rate_hz);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      periodic_mode  <= 1'b0;
      sample_rate_hz <= urc_pkg::RATE_W'(1);
    end else if (cfg_write) begin
      if (paddr[2] == urc_pkg::REG_MODE) begin
        periodic_mode <= pwdata[0];
      end else begin
        sample_rate_hz <= pwdata[urc_pkg::RATE_W-1:0];
      end
    end
  end

  // input register
  assign s1_advance = s1_valid && (!out_valid || out_ready);
  assign in_ready   = !s1_valid || s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_action <= action;
      s1_echo   <= echo_level;
    end
  end

  // tick processing
  assign is_read          = (s1_action == urc_pkg::ACT_READ);
  assign ring_cmd.advance = s1_advance;
  assign ring_cmd.read    = is_read;
  assign ring_cmd.clear   = (s1_action == urc_pkg::ACT_CLEAR);

  assign start = (s1_action == urc_pkg::ACT_MEASURE)
              || (is_read && ring_status.empty && !periodic_mode)
              || fire;

  urc_measure u_measure (
    .clk     (clk),
    .rst     (rst),
    .advance (s1_advance),
    .echo    (s1_echo),
    .start   (start),
    .trig    (trig),
    .push    (push)
  );

  urc_ring u_ring (
    .clk    (clk),
    .rst    (rst),
    .cmd    (ring_cmd),
    .push   (push),
    .status (ring_status)
  );

  urc_timer u_timer (
    .clk            (clk),
    .rst            (rst),
    .advance        (s1_advance),
    .mode_write     (mode_write),
    .action         (s1_action),
    .periodic_mode  (periodic_mode),
    .sample_rate_hz (sample_rate_hz),
    .fire           (fire)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      trigger_level <= trig;
      read_valid    <= ring_status.read_valid;
      read_empty    <= is_read && ring_status.empty;
      distance_cm   <= ring_status.read_valid ? ring_status.read_data : '0;
      sample_done   <= push.valid;
      stored_count  <= ring_status.count;
    end
  end

endmodule
